[rtl/core/tls_pkg.sv]
// Package for the task lifecycle scheduler: state, status and command codes,
// identity type and default sizes. No dependencies.
`timescale 1ns / 1ps
package tls_pkg;
   localparam int TASK_SLOTS_DEF  = 32;
   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int GEN_BITS_DEF    = 16;

   localparam logic [7:0] NO_INDEX = 8'd255;

   localparam logic [2:0] ST_UNUSED       = 3'd0;
   localparam logic [2:0] ST_CONSTRUCTING = 3'd1;
   localparam logic [2:0] ST_READY        = 3'd2;
   localparam logic [2:0] ST_RUNNING      = 3'd3;
   localparam logic [2:0] ST_EXITED       = 3'd4;
   localparam logic [2:0] ST_REAPING      = 3'd5;
   localparam logic [2:0] ST_RETIRED      = 3'd6;

   localparam logic [3:0] S_OK             = 4'd0;
   localparam logic [3:0] S_NOT_INIT       = 4'd1;
   localparam logic [3:0] S_ALREADY        = 4'd2;
   localparam logic [3:0] S_INVALID_HANDLE = 4'd3;
   localparam logic [3:0] S_STALE          = 4'd4;
   localparam logic [3:0] S_INVALID_STATE  = 4'd5;
   localparam logic [3:0] S_NO_SLOT        = 4'd6;
   localparam logic [3:0] S_GEN_EXHAUSTED  = 4'd7;
   localparam logic [3:0] S_NO_PEER        = 4'd8;
   localparam logic [3:0] S_QUEUE_FULL     = 4'd9;
   localparam logic [3:0] S_BOOTSTRAP      = 4'd10;
   localparam logic [3:0] S_RUNNING        = 4'd11;
   localparam logic [3:0] S_RUNNABLE       = 4'd12;
   localparam logic [3:0] S_DOUBLE_REAP    = 4'd13;
   localparam logic [3:0] S_CORRUPTED      = 4'd14;

   localparam logic [3:0] CMD_INIT         = 4'd0;
   localparam logic [3:0] CMD_RESOLVE      = 4'd1;
   localparam logic [3:0] CMD_BEGIN_CREATE = 4'd2;
   localparam logic [3:0] CMD_PUBLISH      = 4'd3;
   localparam logic [3:0] CMD_ABORT_CREATE = 4'd4;
   localparam logic [3:0] CMD_YIELD        = 4'd5;
   localparam logic [3:0] CMD_EXIT         = 4'd6;
   localparam logic [3:0] CMD_BEGIN_REAP   = 4'd7;
   localparam logic [3:0] CMD_FINISH_REAP  = 4'd8;
   localparam logic [3:0] CMD_ABORT_REAP   = 4'd9;

   typedef struct packed {
      logic        boot;
      logic [7:0]  idx;
      logic [15:0] gen;
   } ident_type;
endpackage

[rtl/core/tls_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/core/task_lifecycle_scheduler.sv]
// Task lifecycle scheduler top level: slot table, ready ring, sequencer.
// Depends on tls_pkg and tls_ram.
// begin_create scans one slot a cycle; init clears one slot and ring entry a cycle.
// One command in flight; the next is accepted once the response transaction is taken.
// Reset clears control state; slot and ring contents are rebuilt by init.
`timescale 1ns / 1ps
module task_lifecycle_scheduler #(
   parameter int TASK_SLOTS  = tls_pkg::TASK_SLOTS_DEF,
   parameter int QUEUE_DEPTH = tls_pkg::QUEUE_DEPTH_DEF,
   parameter int GEN_BITS    = tls_pkg::GEN_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_type[3:0], task_index[11:4], handle_generation[27:12], zero[31:28]
   input  logic [31:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[3:0], resolved_state[6:4], new_index[14:7], new_generation[30:15],
   // prev_bootstrap[31], prev_index[39:32], prev_generation[55:40],
   // next_bootstrap[56], next_index[64:57], next_generation[80:65], zero[87:81]
   output logic [87:0]  rsp_tdata
);
   localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int NW = (TASK_SLOTS > QUEUE_DEPTH) ? $clog2(TASK_SLOTS + 1)
                                                  : $clog2(QUEUE_DEPTH + 1);
   localparam int SLW = 3 + GEN_BITS + 1;
   localparam int RW  = 1 + 8 + GEN_BITS;
   localparam int MW  = (GEN_BITS > 16) ? GEN_BITS : 16;
   localparam logic [GEN_BITS-1:0] GEN_MAX = {GEN_BITS{1'b1}};
   localparam logic [GEN_BITS-1:0] GEN_ONE = {{(GEN_BITS-1){1'b0}}, 1'b1};

   localparam logic [3:0] P_IDLE  = 4'd0;
   localparam logic [3:0] P_CLEAR = 4'd1;
   localparam logic [3:0] P_RD    = 4'd2;
   localparam logic [3:0] P_EXEC  = 4'd3;
   localparam logic [3:0] P_SCAN  = 4'd4;
   localparam logic [3:0] P_PUSH  = 4'd5;
   localparam logic [3:0] P_POPRD = 4'd6;
   localparam logic [3:0] P_POP   = 4'd7;
   localparam logic [3:0] P_POPWR = 4'd8;
   localparam logic [3:0] P_DONE  = 4'd9;
   localparam logic [3:0] P_TAILRD = 4'd10;

   typedef struct packed {
      logic                boot;
      logic [7:0]          idx;
      logic [GEN_BITS-1:0] gen;
   } rid_type;

   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  cmd_ff, cmd_in;
   logic [7:0]  hidx_ff, hidx_in;
   logic [15:0] hgen_ff, hgen_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic        retired_ff, retired_in;
   logic        init_ff, init_in;
   logic [2:0]  boot_ff, boot_in;
   rid_type     cur_ff, cur_in;
   rid_type     prev_ff, prev_in, next_ff, next_in;
   logic [QW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [3:0]  status_ff, status_in;
   logic [2:0]  tstate_ff, tstate_in;
   logic [7:0]  nidx_ff, nidx_in;
   logic [15:0] ngen_ff, ngen_in;
   logic        rvalid_ff, rvalid_in;

   logic            s_we, r_we;
   logic [SW-1:0]   s_waddr, s_raddr;
   logic [SLW-1:0]  s_wdata, s_rdata;
   logic [QW-1:0]   r_waddr, r_raddr;
   logic [RW-1:0]   r_wdata, r_rdata;

   tls_ram #(.WIDTH(SLW), .DEPTH(TASK_SLOTS)) u_slots (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr), .rd_data(s_rdata));
   tls_ram #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_ring (
      .clock(clock), .wr_en(r_we), .wr_addr(r_waddr), .wr_data(r_wdata),
      .rd_addr(r_raddr), .rd_data(r_rdata));

   logic [2:0]          sl_st;
   logic [GEN_BITS-1:0] sl_gen;
   logic                sl_q;
   assign sl_st  = s_rdata[SLW-1 -: 3];
   assign sl_gen = s_rdata[GEN_BITS:1];
   assign sl_q   = s_rdata[0];

   rid_type r_id;
   assign r_id = r_rdata;

   logic [QW-1:0] tail;
   logic [CW:0]   tail_sum;
   assign tail_sum = {1'b0, (CW)'(head_ff)} + {1'b0, count_ff};
   always_comb begin
      if (tail_sum >= (CW+1)'(QUEUE_DEPTH)) begin
         tail = QW'(tail_sum - (CW+1)'(QUEUE_DEPTH));
      end else begin
         tail = QW'(tail_sum);
      end
   end

   logic [QW-1:0] head_nx;
   assign head_nx = (32'(head_ff) == QUEUE_DEPTH - 1) ? '0 : head_ff + 1'b1;

   logic hvalid, hmatch;
   assign hvalid = (32'(hidx_ff) < TASK_SLOTS) && (hgen_ff != 16'd0);
   assign hmatch = (MW'(sl_gen) == MW'(hgen_ff));

   rid_type clear_id;
   assign clear_id = '{boot: 1'b0, idx: tls_pkg::NO_INDEX, gen: '0};

   function automatic logic [15:0] g16(input logic [GEN_BITS-1:0] g);
      logic [GEN_BITS+15:0] t;
      t = {16'd0, g};
      return t[15:0];
   endfunction

   assign req_tready = (phase_ff == P_IDLE) && !rvalid_ff;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata = {7'd0, g16(next_ff.gen), next_ff.idx, next_ff.boot,
                       g16(prev_ff.gen), prev_ff.idx, prev_ff.boot, ngen_ff, nidx_ff,
                       tstate_ff, status_ff};

   always_comb begin
      phase_in = phase_ff; cmd_in = cmd_ff; hidx_in = hidx_ff; hgen_in = hgen_ff;
      cnt_in = cnt_ff; retired_in = retired_ff; init_in = init_ff; boot_in = boot_ff;
      cur_in = cur_ff; prev_in = prev_ff; next_in = next_ff; head_in = head_ff;
      count_in = count_ff; status_in = status_ff; tstate_in = tstate_ff;
      nidx_in = nidx_ff; ngen_in = ngen_ff; rvalid_in = rvalid_ff;
      s_we = 1'b0; s_waddr = hidx_ff[SW-1:0]; s_wdata = s_rdata;
      s_raddr = hidx_ff[SW-1:0];
      r_we = 1'b0; r_waddr = tail; r_wdata = clear_id; r_raddr = tail;
      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end
      case (phase_ff)
         P_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in = req_tdata[3:0];
               hidx_in = req_tdata[11:4];
               hgen_in = req_tdata[27:12];
               status_in = tls_pkg::S_OK; tstate_in = tls_pkg::ST_UNUSED;
               nidx_in = tls_pkg::NO_INDEX; ngen_in = '0;
               prev_in = clear_id; next_in = clear_id;
               cnt_in = '0; retired_in = 1'b0;
               s_raddr = req_tdata[4 +: SW];
               if (!(req_tdata[3:0] inside {[tls_pkg::CMD_INIT:tls_pkg::CMD_ABORT_REAP]}))
               begin
                  status_in = tls_pkg::S_INVALID_STATE; phase_in = P_DONE;
               end else if (req_tdata[3:0] == tls_pkg::CMD_INIT) begin
                  if (init_ff) begin
                     status_in = tls_pkg::S_ALREADY; phase_in = P_DONE;
                  end else begin
                     phase_in = P_CLEAR;
                  end
               end else if (!init_ff) begin
                  status_in = tls_pkg::S_NOT_INIT; phase_in = P_DONE;
               end else if (req_tdata[3:0] == tls_pkg::CMD_BEGIN_CREATE) begin
                  s_raddr = '0; phase_in = P_SCAN;
               end else begin
                  phase_in = P_RD;
               end
            end
         end
         P_CLEAR: begin
            if (32'(cnt_ff) < TASK_SLOTS) begin
               s_we = 1'b1; s_waddr = cnt_ff[SW-1:0];
               s_wdata = {tls_pkg::ST_UNUSED, GEN_ONE, 1'b0};
            end
            if (32'(cnt_ff) < QUEUE_DEPTH) begin
               r_we = 1'b1; r_waddr = cnt_ff[QW-1:0]; r_wdata = clear_id;
            end
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) >= TASK_SLOTS - 1 && 32'(cnt_ff) >= QUEUE_DEPTH - 1) begin
               head_in = '0; count_in = '0; boot_in = tls_pkg::ST_RUNNING;
               cur_in = '{boot: 1'b1, idx: tls_pkg::NO_INDEX, gen: '0};
               init_in = 1'b1; phase_in = P_DONE;
            end
         end
         P_SCAN: begin
            s_raddr = SW'(cnt_ff + 1'b1);
            if (sl_st == tls_pkg::ST_UNUSED) begin
               s_we = 1'b1; s_waddr = cnt_ff[SW-1:0];
               s_wdata = {tls_pkg::ST_CONSTRUCTING, sl_gen, sl_q};
               nidx_in = 8'(cnt_ff); ngen_in = g16(sl_gen);
               phase_in = P_DONE;
            end else begin
               if (sl_st == tls_pkg::ST_RETIRED) begin
                  retired_in = 1'b1;
               end
               cnt_in = cnt_ff + 1'b1;
               if (32'(cnt_ff) == TASK_SLOTS - 1) begin
                  status_in = (retired_ff || sl_st == tls_pkg::ST_RETIRED) ?
                              tls_pkg::S_GEN_EXHAUSTED : tls_pkg::S_NO_SLOT;
                  phase_in = P_DONE;
               end
            end
         end
         P_RD: begin
            phase_in = P_EXEC;
            case (cmd_ff)
               tls_pkg::CMD_YIELD: begin
                  if (count_ff == '0) begin
                     status_in = tls_pkg::S_NO_PEER; phase_in = P_DONE;
                  end else begin
                     prev_in = cur_ff; phase_in = P_TAILRD;
                  end
               end
               tls_pkg::CMD_EXIT: begin
                  s_raddr = cur_ff.idx[SW-1:0];
                  if (cur_ff.boot) begin
                     status_in = tls_pkg::S_BOOTSTRAP; phase_in = P_DONE;
                  end else if (count_ff == '0) begin
                     status_in = tls_pkg::S_NO_PEER; phase_in = P_DONE;
                  end else begin
                     prev_in = cur_ff;
                  end
               end
               tls_pkg::CMD_RESOLVE, tls_pkg::CMD_PUBLISH, tls_pkg::CMD_ABORT_CREATE,
               tls_pkg::CMD_BEGIN_REAP, tls_pkg::CMD_FINISH_REAP,
               tls_pkg::CMD_ABORT_REAP: begin
                  if (!hvalid) begin
                     status_in = tls_pkg::S_INVALID_HANDLE; phase_in = P_DONE;
                  end else if (!hmatch) begin
                     status_in = tls_pkg::S_STALE; phase_in = P_DONE;
                  end
               end
               default: begin
                  status_in = tls_pkg::S_INVALID_STATE; phase_in = P_DONE;
               end
            endcase
         end
         P_EXEC: begin
            phase_in = P_DONE;
            case (cmd_ff)
               tls_pkg::CMD_RESOLVE: tstate_in = sl_st;
               tls_pkg::CMD_PUBLISH, tls_pkg::CMD_ABORT_CREATE: begin
                  if (sl_st != tls_pkg::ST_CONSTRUCTING) begin
                     status_in = tls_pkg::S_INVALID_STATE;
                  end else if (cmd_ff == tls_pkg::CMD_ABORT_CREATE) begin
                     s_we = 1'b1; s_wdata = {tls_pkg::ST_UNUSED, sl_gen, sl_q};
                  end else if (32'(count_ff) >= QUEUE_DEPTH) begin
                     status_in = tls_pkg::S_QUEUE_FULL;
                  end else begin
                     prev_in = '{boot: 1'b0, idx: hidx_ff, gen: GEN_BITS'(hgen_ff)};
                     phase_in = P_TAILRD;
                  end
               end
               tls_pkg::CMD_EXIT: begin
                  if (32'(cur_ff.idx) < TASK_SLOTS) begin
                     s_we = 1'b1; s_waddr = cur_ff.idx[SW-1:0];
                     s_wdata = {tls_pkg::ST_EXITED, sl_gen, sl_q};
                  end
                  r_raddr = head_ff; phase_in = P_POPRD;
               end
               tls_pkg::CMD_BEGIN_REAP: begin
                  case (sl_st)
                     tls_pkg::ST_EXITED: begin
                        s_we = 1'b1; s_wdata = {tls_pkg::ST_REAPING, sl_gen, sl_q};
                     end
                     tls_pkg::ST_RUNNING: status_in = tls_pkg::S_RUNNING;
                     tls_pkg::ST_READY: status_in = tls_pkg::S_RUNNABLE;
                     tls_pkg::ST_UNUSED, tls_pkg::ST_RETIRED:
                        status_in = tls_pkg::S_DOUBLE_REAP;
                     default: status_in = tls_pkg::S_INVALID_STATE;
                  endcase
               end
               default: begin
                  if (sl_st != tls_pkg::ST_REAPING) begin
                     status_in = tls_pkg::S_INVALID_STATE;
                  end else begin
                     s_we = 1'b1;
                     if (cmd_ff == tls_pkg::CMD_ABORT_REAP) begin
                        s_wdata = {tls_pkg::ST_EXITED, sl_gen, sl_q};
                     end else if (sl_gen == GEN_MAX) begin
                        s_wdata = {tls_pkg::ST_RETIRED, sl_gen, sl_q};
                     end else begin
                        s_wdata = {tls_pkg::ST_UNUSED, sl_gen + 1'b1, sl_q};
                     end
                  end
               end
            endcase
         end
         P_TAILRD: begin
            r_raddr = tail;
            s_raddr = prev_ff.idx[SW-1:0];
            if (cmd_ff == tls_pkg::CMD_YIELD && 32'(count_ff) >= QUEUE_DEPTH) begin
               status_in = tls_pkg::S_QUEUE_FULL; phase_in = P_DONE;
            end else begin
               phase_in = P_PUSH;
            end
         end
         P_PUSH: begin
            if (r_id != clear_id) begin
               status_in = tls_pkg::S_CORRUPTED; phase_in = P_DONE;
               if (cmd_ff == tls_pkg::CMD_PUBLISH) begin
                  prev_in = clear_id;
               end
            end else begin
               r_we = 1'b1; r_waddr = tail; r_wdata = prev_ff;
               count_in = count_ff + 1'b1;
               if (prev_ff.boot) begin
                  boot_in = tls_pkg::ST_READY;
               end else if (32'(prev_ff.idx) < TASK_SLOTS) begin
                  s_we = 1'b1; s_waddr = prev_ff.idx[SW-1:0];
                  s_wdata = {tls_pkg::ST_READY, sl_gen, 1'b1};
               end
               if (cmd_ff == tls_pkg::CMD_PUBLISH) begin
                  prev_in = clear_id; phase_in = P_DONE;
               end else begin
                  r_raddr = head_ff; phase_in = P_POPRD;
               end
            end
         end
         P_POPRD: begin
            r_raddr = head_ff;
            s_raddr = r_id.idx[SW-1:0];
            phase_in = P_POP;
         end
         P_POP: begin
            s_raddr = r_id.idx[SW-1:0];
            next_in = r_id;
            r_we = 1'b1; r_waddr = head_ff; r_wdata = clear_id;
            head_in = head_nx; count_in = count_ff - 1'b1;
            phase_in = P_DONE;
            if (r_id.boot) begin
               if (r_id.idx == tls_pkg::NO_INDEX && r_id.gen == '0 &&
                   boot_ff == tls_pkg::ST_READY) begin
                  boot_in = tls_pkg::ST_RUNNING; cur_in = r_id;
               end else begin
                  status_in = tls_pkg::S_CORRUPTED;
               end
            end else if (32'(r_id.idx) < TASK_SLOTS && r_id.gen != '0 &&
                         sl_gen == r_id.gen && sl_st == tls_pkg::ST_READY) begin
               s_we = 1'b1; s_waddr = r_id.idx[SW-1:0];
               s_wdata = {tls_pkg::ST_RUNNING, sl_gen, 1'b0};
               cur_in = r_id;
            end else begin
               status_in = tls_pkg::S_CORRUPTED;
            end
         end
         P_DONE: begin
            rvalid_in = 1'b1; phase_in = P_IDLE;
         end
         default: phase_in = P_IDLE;
      endcase
   end

   // slot RAM read data must track the slot the pop reads; P_POPRD fetches it
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE; init_ff <= 1'b0; boot_ff <= tls_pkg::ST_UNUSED;
         cur_ff <= clear_id; head_ff <= '0; count_ff <= '0; rvalid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; init_ff <= init_in; boot_ff <= boot_in;
         cur_ff <= cur_in; head_ff <= head_in; count_ff <= count_in;
         rvalid_ff <= rvalid_in;
      end
      cmd_ff <= cmd_in; hidx_ff <= hidx_in; hgen_ff <= hgen_in; cnt_ff <= cnt_in;
      retired_ff <= retired_in; prev_ff <= prev_in; next_ff <= next_in;
      status_ff <= status_in; tstate_ff <= tstate_in; nidx_ff <= nidx_in;
      ngen_ff <= ngen_in;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (phase_ff == P_IDLE && !rvalid_ff))
      else $error("ready outside idle");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= QUEUE_DEPTH)
      else $error("ring count overflow");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == P_DONE) |=> rvalid_ff)
      else $error("result lost");
endmodule

[test/testbench.sv]
// Self-checking testbench for task_lifecycle_scheduler: directed and random
// command streams checked against an in-bench scheduler model.
// Depends on tls_pkg and the scheduler RTL.
`timescale 1ns / 1ps
module testbench;
   localparam int SLOTS = 32;
   localparam int DEPTH = 64;
   localparam logic [15:0] GEN_TOP = 16'hFFFF;
   localparam logic [3:0] CMD_SPARE = 4'd10;
   localparam logic [3:0] CMD_BAD = 4'd15;

   typedef struct {
      logic [3:0]  status;
      logic [2:0]  tstate;
      logic [7:0]  nidx;
      logic [15:0] ngen;
      tls_pkg::ident_type prev;
      tls_pkg::ident_type next;
   } outcome_type;

   typedef struct {
      logic [31:0] data;
      bit          drain;
      outcome_type want;
   } command_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [87:0] rsp_tdata;

   task_lifecycle_scheduler uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   // scheduler model state
   logic [2:0]  sl_state [SLOTS];
   logic [15:0] sl_gen [SLOTS];
   bit          sl_queued [SLOTS];
   tls_pkg::ident_type ring [DEPTH];
   int          ring_head, ring_count;
   tls_pkg::ident_type running_task;
   logic [2:0]  boot_state;
   bit          started;

   command_type  pending_cmds[$];
   outcome_type  awaited[$];
   int        errors = 0;
   int        results_seen = 0;
   int        status_hits[16];

   function automatic tls_pkg::ident_type no_task();
      return '{boot: 1'b0, idx: tls_pkg::NO_INDEX, gen: 16'd0};
   endfunction

   function automatic bit is_ready(tls_pkg::ident_type t);
      if (t.boot) return t.idx == tls_pkg::NO_INDEX && t.gen == 0 &&
                         boot_state == tls_pkg::ST_READY;
      return t.idx < SLOTS && t.gen != 0 && sl_gen[t.idx] == t.gen &&
         sl_state[t.idx] == tls_pkg::ST_READY;
   endfunction

   function automatic logic [3:0] enqueue_ready(tls_pkg::ident_type t);
      int tail;
      if (ring_count >= DEPTH) return tls_pkg::S_QUEUE_FULL;
      tail = (ring_head + ring_count) % DEPTH;
      if (ring[tail] != no_task()) return tls_pkg::S_CORRUPTED;
      ring[tail] = t;
      ring_count++;
      if (t.boot) boot_state = tls_pkg::ST_READY;
      else if (t.idx < SLOTS) begin
         sl_state[t.idx] = tls_pkg::ST_READY;
         sl_queued[t.idx] = 1;
      end
      return tls_pkg::S_OK;
   endfunction

   function automatic logic [3:0] dequeue_ready(output tls_pkg::ident_type t);
      t = no_task();
      if (ring_count == 0) return tls_pkg::S_NO_PEER;
      t = ring[ring_head];
      ring[ring_head] = no_task();
      ring_head = (ring_head + 1) % DEPTH;
      ring_count--;
      if (!is_ready(t)) return tls_pkg::S_CORRUPTED;
      if (t.boot) boot_state = tls_pkg::ST_RUNNING;
      else begin
         sl_state[t.idx] = tls_pkg::ST_RUNNING;
         sl_queued[t.idx] = 0;
      end
      running_task = t;
      return tls_pkg::S_OK;
   endfunction

   function automatic logic [3:0] look_up(logic [7:0] idx, logic [15:0] g,
                                          output logic [2:0] st);
      st = tls_pkg::ST_UNUSED;
      if (!started) return tls_pkg::S_NOT_INIT;
      if (idx >= SLOTS || g == 0) return tls_pkg::S_INVALID_HANDLE;
      if (sl_gen[idx] != g) return tls_pkg::S_STALE;
      st = sl_state[idx];
      return tls_pkg::S_OK;
   endfunction

   function automatic void clear_model();
      for (int i = 0; i < SLOTS; i++) begin
         sl_state[i] = tls_pkg::ST_UNUSED;
         sl_gen[i] = 0;
         sl_queued[i] = 0;
      end
      for (int i = 0; i < DEPTH; i++) ring[i] = no_task();
      ring_head = 0;
      ring_count = 0;
      running_task = no_task();
      boot_state = tls_pkg::ST_UNUSED;
      started = 0;
   endfunction

   function automatic outcome_type schedule_step(logic [3:0] cmd, logic [7:0] idx,
                                                 logic [15:0] g);
      outcome_type o;
      logic [2:0] st;
      bit seen_retired;
      o.status = tls_pkg::S_OK;
      o.tstate = tls_pkg::ST_UNUSED;
      o.nidx = tls_pkg::NO_INDEX;
      o.ngen = 0;
      o.prev = no_task();
      o.next = no_task();
      case (cmd)
         tls_pkg::CMD_INIT: begin
            if (started) o.status = tls_pkg::S_ALREADY;
            else begin
               clear_model();
               for (int i = 0; i < SLOTS; i++) sl_gen[i] = 16'd1;
               boot_state = tls_pkg::ST_RUNNING;
               running_task = '{boot: 1'b1, idx: tls_pkg::NO_INDEX, gen: 16'd0};
               started = 1;
            end
         end
         tls_pkg::CMD_RESOLVE: begin
            o.status = look_up(idx, g, st);
            if (o.status == tls_pkg::S_OK) o.tstate = st;
         end
         tls_pkg::CMD_BEGIN_CREATE: begin
            if (!started) o.status = tls_pkg::S_NOT_INIT;
            else begin
               seen_retired = 0;
               o.status = tls_pkg::S_NO_SLOT;
               for (int i = 0; i < SLOTS; i++) begin
                  if (sl_state[i] == tls_pkg::ST_RETIRED) seen_retired = 1;
                  else if (sl_state[i] == tls_pkg::ST_UNUSED) begin
                     sl_state[i] = tls_pkg::ST_CONSTRUCTING;
                     o.nidx = 8'(i);
                     o.ngen = sl_gen[i];
                     o.status = tls_pkg::S_OK;
                     break;
                  end
               end
               if (o.status != tls_pkg::S_OK && seen_retired)
                  o.status = tls_pkg::S_GEN_EXHAUSTED;
            end
         end
         tls_pkg::CMD_PUBLISH, tls_pkg::CMD_ABORT_CREATE: begin
            o.status = look_up(idx, g, st);
            if (o.status == tls_pkg::S_OK) begin
               if (st != tls_pkg::ST_CONSTRUCTING) o.status = tls_pkg::S_INVALID_STATE;
               else if (cmd == tls_pkg::CMD_ABORT_CREATE) sl_state[idx] = tls_pkg::ST_UNUSED;
               else o.status = enqueue_ready('{boot: 1'b0, idx: idx, gen: g});
            end
         end
         tls_pkg::CMD_YIELD: begin
            if (!started) o.status = tls_pkg::S_NOT_INIT;
            else if (ring_count == 0) o.status = tls_pkg::S_NO_PEER;
            else begin
               o.prev = running_task;
               o.status = enqueue_ready(o.prev);
               if (o.status == tls_pkg::S_OK) o.status = dequeue_ready(o.next);
            end
         end
         tls_pkg::CMD_EXIT: begin
            if (!started) o.status = tls_pkg::S_NOT_INIT;
            else if (running_task.boot) o.status = tls_pkg::S_BOOTSTRAP;
            else if (ring_count == 0) o.status = tls_pkg::S_NO_PEER;
            else begin
               o.prev = running_task;
               if (o.prev.idx < SLOTS) sl_state[o.prev.idx] = tls_pkg::ST_EXITED;
               o.status = dequeue_ready(o.next);
            end
         end
         tls_pkg::CMD_BEGIN_REAP: begin
            o.status = look_up(idx, g, st);
            if (o.status == tls_pkg::S_OK) begin
               if (st == tls_pkg::ST_EXITED) sl_state[idx] = tls_pkg::ST_REAPING;
               else if (st == tls_pkg::ST_RUNNING) o.status = tls_pkg::S_RUNNING;
               else if (st == tls_pkg::ST_READY) o.status = tls_pkg::S_RUNNABLE;
               else if (st == tls_pkg::ST_UNUSED || st == tls_pkg::ST_RETIRED)
                  o.status = tls_pkg::S_DOUBLE_REAP;
               else o.status = tls_pkg::S_INVALID_STATE;
            end
         end
         tls_pkg::CMD_FINISH_REAP, tls_pkg::CMD_ABORT_REAP: begin
            o.status = look_up(idx, g, st);
            if (o.status == tls_pkg::S_OK) begin
               if (st != tls_pkg::ST_REAPING) o.status = tls_pkg::S_INVALID_STATE;
               else if (cmd == tls_pkg::CMD_ABORT_REAP) sl_state[idx] = tls_pkg::ST_EXITED;
               else if (sl_gen[idx] >= GEN_TOP) sl_state[idx] = tls_pkg::ST_RETIRED;
               else begin
                  sl_gen[idx]++;
                  sl_state[idx] = tls_pkg::ST_UNUSED;
               end
            end
         end
         default: o.status = tls_pkg::S_INVALID_STATE;
      endcase
      return o;
   endfunction

   function automatic void add_command(logic [3:0] cmd, logic [7:0] idx,
                                       logic [15:0] g, bit drain = 0);
      command_type c;
      c.data = {4'd0, g, idx, cmd};
      c.drain = drain;
      c.want = schedule_step(cmd, idx, g);
      pending_cmds.push_back(c);
   endfunction

   // pick a handle to a slot in the wanted state, now and then a stale or bogus one
   function automatic void add_handle_command(logic [3:0] cmd, logic [2:0] wanted);
      int start, k;
      start = $urandom_range(0, SLOTS - 1);
      for (int j = 0; j < SLOTS; j++) begin
         k = (start + j) % SLOTS;
         if (sl_state[k] == wanted && $urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 15) == 0) add_command(cmd, 8'(k), sl_gen[k] - 16'd1);
            else add_command(cmd, 8'(k), sl_gen[k]);
            return;
         end
      end
      add_command(cmd, 8'($urandom_range(0, 35)), 16'($urandom_range(0, 3)));
   endfunction

   function automatic void build_stimulus();
      int r;
      clear_model();
      // before init, then init handling, bad codes and bad handles
      add_command(tls_pkg::CMD_RESOLVE, 0, 1);
      add_command(tls_pkg::CMD_YIELD, 0, 0);
      add_command(tls_pkg::CMD_BEGIN_CREATE, 0, 0);
      add_command(CMD_BAD, 0, 0);
      add_command(tls_pkg::CMD_INIT, 0, 0);
      add_command(tls_pkg::CMD_INIT, 8'hFF, 16'hFFFF);
      add_command(CMD_SPARE, 0, 1);
      add_command(CMD_BAD, 8'hFF, 16'hFFFF);
      add_command(tls_pkg::CMD_EXIT, 0, 0);
      add_command(tls_pkg::CMD_YIELD, 0, 0);
      add_command(tls_pkg::CMD_RESOLVE, 8'hFF, 1);
      add_command(tls_pkg::CMD_RESOLVE, 8'(SLOTS), 1);
      add_command(tls_pkg::CMD_RESOLVE, 0, 0);
      add_command(tls_pkg::CMD_RESOLVE, 0, 16'hFFFF);
      // one task through its whole life
      add_command(tls_pkg::CMD_BEGIN_CREATE, 0, 0);
      add_command(tls_pkg::CMD_RESOLVE, 0, 1);
      add_command(tls_pkg::CMD_ABORT_CREATE, 0, 1);
      add_command(tls_pkg::CMD_BEGIN_CREATE, 0, 0);
      add_command(tls_pkg::CMD_PUBLISH, 0, 1);
      add_command(tls_pkg::CMD_BEGIN_REAP, 0, 1);
      add_command(tls_pkg::CMD_YIELD, 0, 0);
      add_command(tls_pkg::CMD_BEGIN_REAP, 0, 1);
      add_command(tls_pkg::CMD_EXIT, 0, 0);
      add_command(tls_pkg::CMD_BEGIN_REAP, 0, 1);
      add_command(tls_pkg::CMD_ABORT_REAP, 0, 1);
      add_command(tls_pkg::CMD_BEGIN_REAP, 0, 1);
      add_command(tls_pkg::CMD_FINISH_REAP, 0, 1);
      add_command(tls_pkg::CMD_BEGIN_REAP, 0, 1);
      add_command(tls_pkg::CMD_BEGIN_REAP, 0, 2);
      for (int n = 0; n < 850; n++) begin
         if (n % 211 == 100) begin
            add_command(tls_pkg::CMD_RESOLVE, 8'($urandom_range(0, 31)), 1, 1);
            continue;
         end
         if (n == 400)
            for (int j = 0; j < SLOTS + 1; j++) add_command(tls_pkg::CMD_BEGIN_CREATE, 0, 0);
         r = $urandom_range(0, 99);
         if (r < 5)
            add_command(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)));
         else if (r < 22)
            add_command(tls_pkg::CMD_BEGIN_CREATE, 8'($urandom_range(0, 255)), 0);
         else if (r < 38) add_handle_command(tls_pkg::CMD_PUBLISH, tls_pkg::ST_CONSTRUCTING);
         else if (r < 42)
            add_handle_command(tls_pkg::CMD_ABORT_CREATE, tls_pkg::ST_CONSTRUCTING);
         else if (r < 57) add_command(tls_pkg::CMD_YIELD, 0, 0);
         else if (r < 67) add_command(tls_pkg::CMD_EXIT, 0, 0);
         else if (r < 77) add_handle_command(tls_pkg::CMD_BEGIN_REAP, tls_pkg::ST_EXITED);
         else if (r < 80)
            add_handle_command(tls_pkg::CMD_BEGIN_REAP, 3'($urandom_range(0, 6)));
         else if (r < 88) add_handle_command(tls_pkg::CMD_FINISH_REAP, tls_pkg::ST_REAPING);
         else if (r < 92) add_handle_command(tls_pkg::CMD_ABORT_REAP, tls_pkg::ST_REAPING);
         else if (r < 98)
            add_handle_command(tls_pkg::CMD_RESOLVE, 3'($urandom_range(0, 6)));
         else add_command(tls_pkg::CMD_INIT, 0, 0);
      end
   endfunction

   // driver: bursts with random gaps, some items wait for the block to drain
   int       burst_left = 0;
   int       gap_left = 0;
   outcome_type offered_want;

   always @(posedge clock) begin
      automatic bit busy = req_tvalid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited.push_back(offered_want);
            busy = 0;
         end
         if (!busy) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_cmds.size() > 0 &&
                         (!pending_cmds[0].drain || awaited.size() == 0)) begin
               req_tdata <= pending_cmds[0].data;
               offered_want = pending_cmds[0].want;
               void'(pending_cmds.pop_front());
               busy = 1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_tvalid <= busy;
      end
   end

   // monitor: stall pattern, one long hold-off, field checks
   int cycle_count = 0;
   int hold_left = 0;
   bit held_once = 0;

   always @(posedge clock) begin
      outcome_type want;
      logic [3:0]  got_status;
      logic [2:0]  got_tstate;
      logic [7:0]  got_nidx;
      logic [15:0] got_ngen;
      tls_pkg::ident_type got_prev, got_next;
      cycle_count++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            {got_next.gen, got_next.idx, got_next.boot, got_prev.gen, got_prev.idx,
             got_prev.boot, got_ngen, got_nidx, got_tstate, got_status} = rsp_tdata[80:0];
            results_seen++;
            if (awaited.size() == 0) begin
               $error("unexpected transaction, status %0d", got_status);
               errors++;
            end else begin
               want = awaited.pop_front();
               status_hits[want.status]++;
               if (got_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got_status);
                  errors++;
               end
               if (got_tstate !== want.tstate) begin
                  $error("resolved_state: expected %0d, got %0d", want.tstate, got_tstate);
                  errors++;
               end
               if (got_nidx !== want.nidx) begin
                  $error("new_index: expected %0d, got %0d", want.nidx, got_nidx);
                  errors++;
               end
               if (got_ngen !== want.ngen) begin
                  $error("new_generation: expected %0d, got %0d", want.ngen, got_ngen);
                  errors++;
               end
               if (got_prev !== want.prev) begin
                  $error("prev task: expected %p, got %p", want.prev, got_prev);
                  errors++;
               end
               if (got_next !== want.next) begin
                  $error("next task: expected %p, got %p", want.next, got_next);
                  errors++;
               end
            end
         end
         if (!held_once && results_seen == 400) begin
            held_once = 1;
            hold_left = 200;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if ((cycle_count / 256) % 3 == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ((cycle_count % 9) >= 3) && ($urandom_range(0, 3) != 0);
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_cmds.size() > 0 || req_tvalid || awaited.size() > 0);
      repeat (100) @(posedge clock);
      if (awaited.size() > 0) begin
         $error("%0d transactions never arrived", awaited.size());
         errors++;
      end
      $display("covered %0d results: ok %0d, stale %0d, no_slot %0d, no_peer %0d",
               results_seen, status_hits[tls_pkg::S_OK], status_hits[tls_pkg::S_STALE],
               status_hits[tls_pkg::S_NO_SLOT], status_hits[tls_pkg::S_NO_PEER]);
      if (errors == 0)
         $display("task_lifecycle_scheduler test passed");
      else
         $display("task_lifecycle_scheduler test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("task_lifecycle_scheduler test failed");
      $finish;
   end
endmodule

[sim.f]
rtl/core/tls_pkg.sv
rtl/core/tls_ram.sv
rtl/core/task_lifecycle_scheduler.sv
test/testbench.sv
